// File: rtl/core/npae_pkg.sv
package npae_pkg;

  localparam int ADDR_W      = 15;
  localparam int DATA_W      = 8;
  localparam int COORD_W     = 8;
  localparam int NIB_W       = 4;
  localparam int STORE_DEPTH = 32768;

  // highest byte address that pixel writes must leave untouched
  localparam logic [ADDR_W-1:0] PROTECT_LIMIT = 15'h0BFF;

  typedef enum logic [3:0] {
    CMD_SET_X   = 4'd0,
    CMD_SET_Y   = 4'd1,
    CMD_X_HOLD  = 4'd2,
    CMD_Y_HOLD  = 4'd3,
    CMD_X_DIR   = 4'd4,
    CMD_Y_DIR   = 4'd5,
    CMD_PIX_RD  = 4'd6,
    CMD_PIX_WR  = 4'd7,
    CMD_BYTE_WR = 4'd8
  } cmd_t;

  // request held between the store read and the write-back
  typedef struct packed {
    cmd_t              cmd;
    logic [ADDR_W-1:0] addr;
    logic              x_odd;
    logic [DATA_W-1:0] data;
  } stage_t;

endpackage

// File: rtl/core/npae_if.sv
interface npae_in_if;
  logic                         valid;
  logic                         ready;
  logic [3:0]                   command;
  logic [npae_pkg::ADDR_W-1:0]  byte_address;
  logic [npae_pkg::DATA_W-1:0]  data;

  modport source (output valid, output command, output byte_address, output data,
                  input ready);
  modport sink   (input valid, input command, input byte_address, input data,
                  output ready);
endinterface

interface npae_out_if;
  logic                         valid;
  logic                         ready;
  logic [npae_pkg::DATA_W-1:0]  read_data;

  modport source (output valid, output read_data, input ready);
  modport sink   (input valid, input read_data, output ready);
endinterface

// File: rtl/core/npae_ram.sv
module npae_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/nibble_pixel_access_engine_core.sv
// Pixel access engine for a 4-bit-per-pixel frame store of 32K bytes. Each request
// (coordinate set, hold/direction flag, pixel read, pixel write, direct byte write)
// gives exactly one response, which carries the pixel nibble in bits 7..4 on a pixel
// read and zero otherwise. One request is taken every cycle while responses are
// drained; responses pass the write-back stage and output register. The rate is set by
// the store RAM: pixel accesses read the byte in the request cycle and write the
// merged byte back on leaving that stage, with a forwarding register covering a
// back-to-back access to the same byte. Coordinates step at request time, so no
// interlock is needed. Store bytes are undefined until written; no clearing pass
// follows reset, and pixel writes below byte address 0x0C00 leave the store unchanged.
module nibble_pixel_access_engine_core (
  input  logic        clk,
  input  logic        rst_n,
  npae_in_if.sink     in_req,
  npae_out_if.source  out_rsp
);

  npae_pkg::cmd_t                     cmd_in;
  logic                               acc;
  logic                               pix_in;
  logic                               flag_in;
  logic [npae_pkg::ADDR_W-1:0]        pix_addr;

  logic [npae_pkg::COORD_W-1:0]       x_coord_r, x_coord_nxt;
  logic [npae_pkg::COORD_W-1:0]       y_coord_r, y_coord_nxt;
  logic                               x_hold_r, x_hold_nxt;
  logic                               y_hold_r, y_hold_nxt;
  logic                               x_down_r, x_down_nxt;
  logic                               y_down_r, y_down_nxt;

  logic                               s1_valid_r;
  npae_pkg::stage_t                   s1_r;
  logic                               s1_adv;

  logic                               fwd_valid_r;
  logic [npae_pkg::DATA_W-1:0]        fwd_data_r;
  logic                               hazard;

  logic [npae_pkg::DATA_W-1:0]        ram_rdata;
  logic [npae_pkg::DATA_W-1:0]        cur;
  logic [npae_pkg::DATA_W-1:0]        merged;
  logic [npae_pkg::DATA_W-1:0]        result;
  logic                               wr_en;
  logic [npae_pkg::DATA_W-1:0]        wr_data;

  logic                               out_valid_r;
  logic [npae_pkg::DATA_W-1:0]        out_data_r;

  // request handshake
  assign cmd_in  = npae_pkg::cmd_t'(in_req.command);
  assign s1_adv  = s1_valid_r && (!out_valid_r || out_rsp.ready);
  assign in_req.ready = !s1_valid_r || s1_adv;
  assign acc     = in_req.valid && in_req.ready;
  assign pix_in  = (cmd_in == npae_pkg::CMD_PIX_RD) || (cmd_in == npae_pkg::CMD_PIX_WR);
  assign flag_in = (in_req.data != '0);
  assign pix_addr = {y_coord_r, x_coord_r[npae_pkg::COORD_W-1:1]};

  // update coordinates and flags at request time
  always_comb begin
    x_coord_nxt = x_coord_r;
    y_coord_nxt = y_coord_r;
    x_hold_nxt  = x_hold_r;
    y_hold_nxt  = y_hold_r;
    x_down_nxt  = x_down_r;
    y_down_nxt  = y_down_r;
    if (acc) begin
      unique case (cmd_in)
        npae_pkg::CMD_SET_X:  x_coord_nxt = in_req.data;
        npae_pkg::CMD_SET_Y:  y_coord_nxt = in_req.data;
        npae_pkg::CMD_X_HOLD: x_hold_nxt  = flag_in;
        npae_pkg::CMD_Y_HOLD: y_hold_nxt  = flag_in;
        npae_pkg::CMD_X_DIR:  x_down_nxt  = flag_in;
        npae_pkg::CMD_Y_DIR:  y_down_nxt  = flag_in;
        npae_pkg::CMD_PIX_RD, npae_pkg::CMD_PIX_WR: begin
          if (!x_hold_r) begin
            x_coord_nxt = x_down_r ? x_coord_r - 8'd1 : x_coord_r + 8'd1;
          end
          if (!y_hold_r) begin
            y_coord_nxt = y_down_r ? y_coord_r - 8'd1 : y_coord_r + 8'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_coord_r <= '0;
      y_coord_r <= '0;
      x_hold_r  <= 1'b0;
      y_hold_r  <= 1'b0;
      x_down_r  <= 1'b0;
      y_down_r  <= 1'b0;
    end else begin
      x_coord_r <= x_coord_nxt;
      y_coord_r <= y_coord_nxt;
      x_hold_r  <= x_hold_nxt;
      y_hold_r  <= y_hold_nxt;
      x_down_r  <= x_down_nxt;
      y_down_r  <= y_down_nxt;
    end
  end

  // advance the request into the write-back stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_r.cmd   <= cmd_in;
      s1_r.addr  <= (cmd_in == npae_pkg::CMD_BYTE_WR) ? in_req.byte_address : pix_addr;
      s1_r.x_odd <= x_coord_r[0];
      s1_r.data  <= in_req.data;
    end
  end

  // merge the nibble and pick the response
  assign cur    = fwd_valid_r ? fwd_data_r : ram_rdata;
  assign result = (s1_r.cmd != npae_pkg::CMD_PIX_RD) ? '0 :
                  s1_r.x_odd ? {cur[npae_pkg::NIB_W-1:0], 4'b0000}
                             : {cur[npae_pkg::DATA_W-1:npae_pkg::NIB_W], 4'b0000};
  assign merged = s1_r.x_odd
                ? {cur[npae_pkg::DATA_W-1:npae_pkg::NIB_W],
                   s1_r.data[npae_pkg::DATA_W-1:npae_pkg::NIB_W]}
                : {s1_r.data[npae_pkg::DATA_W-1:npae_pkg::NIB_W],
                   cur[npae_pkg::NIB_W-1:0]};

  // write back once, as the request leaves the stage
  assign wr_en   = s1_adv &&
                   (((s1_r.cmd == npae_pkg::CMD_PIX_WR) &&
                     (s1_r.addr > npae_pkg::PROTECT_LIMIT)) ||
                    (s1_r.cmd == npae_pkg::CMD_BYTE_WR));
  assign wr_data = (s1_r.cmd == npae_pkg::CMD_BYTE_WR) ? s1_r.data : merged;

  // forward a write that lands on the byte being read in the same cycle
  assign hazard = acc && pix_in && wr_en && (s1_r.addr == pix_addr);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_valid_r <= 1'b0;
    end else if (acc) begin
      fwd_valid_r <= hazard;
    end else if (s1_adv) begin
      fwd_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (hazard) begin
      fwd_data_r <= wr_data;
    end
  end

  npae_ram #(
    .WIDTH (npae_pkg::DATA_W),
    .DEPTH (npae_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_r.addr),
    .wdata (wr_data),
    .re    (acc && pix_in),
    .raddr (pix_addr),
    .rdata (ram_rdata)
  );

  // hold the response until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= result;
    end
  end

  assign out_rsp.valid     = out_valid_r;
  assign out_rsp.read_data = out_data_r;

  // a stalled stage keeps its request
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_r)))
    else $error("write-back stage lost its request while stalled");

  // forwarded data only ever belongs to a pixel access in the stage
  a_fwd_owner: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_valid_r |-> (s1_valid_r &&
                     ((s1_r.cmd == npae_pkg::CMD_PIX_RD) ||
                      (s1_r.cmd == npae_pkg::CMD_PIX_WR))))
    else $error("forward flag set without a pixel access");

  // pixel writes never reach the protected region
  a_protect: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && (s1_r.cmd == npae_pkg::CMD_PIX_WR)) |->
      (s1_r.addr > npae_pkg::PROTECT_LIMIT))
    else $error("pixel write into protected region");

  // responses carry the nibble in the upper half only
  a_low_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r[npae_pkg::NIB_W-1:0] == '0))
    else $error("response has nonzero low nibble");

endmodule

// File: verif/tb_nibble_pixel_access_engine_core.sv
module tb_nibble_pixel_access_engine_core;
  import npae_pkg::*;

  // command codes the block treats as no-ops
  localparam logic [3:0] CMD_RESERVED_FIRST = 4'd9;
  localparam logic [3:0] CMD_RESERVED_LAST  = 4'd15;

  localparam int REQUEST_TARGET = 1950;
  localparam int QUIET_TAIL     = 150;
  localparam int LONG_HOLD      = 300;
  localparam int LONG_HOLD_AT   = 400;
  localparam int DRAIN_CYCLES   = 20;

  typedef struct packed {
    logic [3:0]        command;
    logic [ADDR_W-1:0] byte_address;
    logic [DATA_W-1:0] data;
  } pix_req_t;

  typedef struct packed {
    logic [3:0]        command;
    logic [DATA_W-1:0] read_data;
  } pix_rsp_t;

  logic clk = 1'b0;
  logic rst_n;

  npae_in_if  in_req ();
  npae_out_if out_rsp ();

  nibble_pixel_access_engine_core uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp)
  );

  always #10 clk = ~clk;

  // shadow of the engine: cursor, axis flags and frame store
  logic [COORD_W-1:0] x_pos, y_pos;
  logic               x_frozen, y_frozen, x_backward, y_backward;
  logic [DATA_W-1:0]  frame_mem [STORE_DEPTH];
  bit                 frame_written [STORE_DEPTH];

  pix_req_t request_q [$];
  pix_rsp_t read_data_q [$];

  int total_requests;
  int requests_sent;
  int results_checked;
  int errors;
  int src_gap, sink_gap, hold_left;
  bit long_hold_done;
  int stalled_cycles;
  int n_pix_rd, n_pix_wr, n_protected, n_byte_wr;

  function automatic logic [ADDR_W-1:0] cursor_addr();
    return {y_pos, x_pos[COORD_W-1:1]};
  endfunction

  // step every axis that is not frozen, wrapping at eight bits
  function automatic void step_cursor();
    if (!x_frozen) x_pos = x_backward ? x_pos - 8'd1 : x_pos + 8'd1;
    if (!y_frozen) y_pos = y_backward ? y_pos - 8'd1 : y_pos + 8'd1;
  endfunction

  // apply one request to the shadow and return the read_data it yields
  function automatic logic [DATA_W-1:0] predict_read_data(pix_req_t r);
    logic [ADDR_W-1:0] a;
    logic [DATA_W-1:0] rd;
    logic              flag;
    a    = cursor_addr();
    rd   = '0;
    flag = (r.data != '0);
    case (r.command)
      CMD_SET_X:  x_pos = r.data;
      CMD_SET_Y:  y_pos = r.data;
      CMD_X_HOLD: x_frozen = flag;
      CMD_Y_HOLD: y_frozen = flag;
      CMD_X_DIR:  x_backward = flag;
      CMD_Y_DIR:  y_backward = flag;
      CMD_PIX_RD: begin
        rd = x_pos[0] ? {frame_mem[a][3:0], 4'h0} : {frame_mem[a][7:4], 4'h0};
        step_cursor();
      end
      CMD_PIX_WR: begin
        if (a > PROTECT_LIMIT) begin
          if (x_pos[0]) frame_mem[a][3:0] = r.data[7:4];
          else frame_mem[a][7:4] = r.data[7:4];
        end
        step_cursor();
      end
      CMD_BYTE_WR: begin
        frame_mem[r.byte_address]     = r.data;
        frame_written[r.byte_address] = 1'b1;
      end
      default: ;
    endcase
    return rd;
  endfunction

  task automatic queue_request(logic [3:0] cmd, logic [ADDR_W-1:0] addr,
                               logic [DATA_W-1:0] data);
    pix_req_t r;
    pix_rsp_t e;
    r.command      = cmd;
    r.byte_address = addr;
    r.data         = data;
    if (cmd == CMD_PIX_RD) n_pix_rd++;
    if (cmd == CMD_PIX_WR) begin
      n_pix_wr++;
      if (cursor_addr() <= PROTECT_LIMIT) n_protected++;
    end
    if (cmd == CMD_BYTE_WR) n_byte_wr++;
    e.command   = cmd;
    e.read_data = predict_read_data(r);
    request_q.push_back(r);
    read_data_q.push_back(e);
  endtask

  // random flag byte: zero half the time, else any nonzero value
  function automatic logic [DATA_W-1:0] flag_byte();
    return ($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
  endfunction

  // drive requests from the pending queue with random idle bursts
  always @(posedge clk) begin : drive_requests
    pix_req_t nxt;
    bit       quiet;
    quiet = (requests_sent >= total_requests - QUIET_TAIL);
    if (!rst_n) begin
      in_req.valid <= 1'b0;
      src_gap      <= 0;
    end else begin
      if (in_req.valid && in_req.ready) requests_sent <= requests_sent + 1;
      if (in_req.valid && !in_req.ready) begin
        stalled_cycles <= stalled_cycles + 1;
      end else if (src_gap > 0) begin
        src_gap      <= src_gap - 1;
        in_req.valid <= 1'b0;
      end else if (request_q.size() == 0) begin
        in_req.valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        src_gap      <= $urandom_range(0, 9);
        in_req.valid <= 1'b0;
      end else begin
        nxt                  = request_q.pop_front();
        in_req.valid        <= 1'b1;
        in_req.command      <= nxt.command;
        in_req.byte_address <= nxt.byte_address;
        in_req.data         <= nxt.data;
      end
    end
  end

  // pace the response side: short random stalls plus one long hold-off
  always @(posedge clk) begin : pace_responses
    bit quiet;
    quiet = (requests_sent >= total_requests - QUIET_TAIL);
    if (!rst_n) begin
      out_rsp.ready  <= 1'b0;
      sink_gap       <= 0;
      hold_left      <= 0;
      long_hold_done <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      out_rsp.ready <= 1'b0;
    end else if (!long_hold_done && requests_sent >= LONG_HOLD_AT) begin
      long_hold_done <= 1'b1;
      hold_left      <= LONG_HOLD - 1;
      out_rsp.ready  <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap      <= sink_gap - 1;
      out_rsp.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      sink_gap      <= $urandom_range(0, 9);
      out_rsp.ready <= 1'b0;
    end else begin
      out_rsp.ready <= 1'b1;
    end
  end

  // compare each accepted response with the oldest prediction
  always @(posedge clk) begin : check_responses
    pix_rsp_t want;
    if (rst_n && out_rsp.valid && out_rsp.ready) begin
      if (read_data_q.size() == 0) begin
        $display("%0t: unexpected response: expected none, actual read_data=%02h",
                 $time, out_rsp.read_data);
        errors++;
      end else begin
        want = read_data_q.pop_front();
        results_checked++;
        if (out_rsp.read_data !== want.read_data) begin
          $display("%0t: read_data mismatch (command %0d): expected %02h actual %02h",
                   $time, want.command, want.read_data, out_rsp.read_data);
          errors++;
        end
      end
    end
  end

  initial begin : run_test
    int               pick;
    logic [3:0]       cmd;
    logic [DATA_W-1:0] data;
    logic [ADDR_W-1:0] a;

    rst_n               = 1'b0;
    in_req.valid        = 1'b0;
    in_req.command      = '0;
    in_req.byte_address = '0;
    in_req.data         = '0;
    out_rsp.ready       = 1'b0;
    total_requests      = REQUEST_TARGET;
    x_pos      = '0;
    y_pos      = '0;
    x_frozen   = 1'b0;
    y_frozen   = 1'b0;
    x_backward = 1'b0;
    y_backward = 1'b0;

    // directed: store corners, wrap on both axes, protected write, forwarding
    queue_request(CMD_BYTE_WR, 15'h7FFF, 8'h9C);
    queue_request(CMD_BYTE_WR, 15'h0BFF, 8'h12);
    queue_request(CMD_BYTE_WR, 15'h0C00, 8'hA5);
    queue_request(CMD_SET_Y,   15'h0000, 8'hFF);
    queue_request(CMD_SET_X,   15'h7FFF, 8'hFE);
    queue_request(CMD_PIX_RD,  15'h0000, 8'h00);
    queue_request(CMD_SET_Y,   15'h0000, 8'hFF);
    queue_request(CMD_PIX_RD,  15'h7FFF, 8'hFF);
    queue_request(CMD_Y_HOLD,  15'h0000, 8'h01);
    queue_request(CMD_SET_Y,   15'h0000, 8'h17);
    queue_request(CMD_X_HOLD,  15'h0000, 8'h80);
    queue_request(CMD_SET_X,   15'h0000, 8'hFF);
    queue_request(CMD_PIX_WR,  15'h0000, 8'hF0);
    queue_request(CMD_PIX_RD,  15'h0000, 8'h00);
    queue_request(CMD_SET_Y,   15'h0000, 8'h18);
    queue_request(CMD_SET_X,   15'h0000, 8'h01);
    queue_request(CMD_PIX_WR,  15'h0000, 8'h7B);
    queue_request(CMD_PIX_RD,  15'h0000, 8'h00);
    queue_request(CMD_X_HOLD,  15'h0000, 8'h00);
    queue_request(CMD_X_DIR,   15'h0000, 8'hFF);
    queue_request(CMD_PIX_RD,  15'h0000, 8'h00);
    queue_request(CMD_PIX_RD,  15'h0000, 8'h00);
    queue_request(CMD_Y_DIR,   15'h0000, 8'h01);
    queue_request(CMD_Y_HOLD,  15'h0000, 8'h00);
    queue_request(CMD_X_DIR,   15'h0000, 8'h00);
    queue_request(CMD_RESERVED_FIRST, 15'h7FFF, 8'hFF);
    queue_request(CMD_RESERVED_LAST,  15'h5555, 8'hAA);

    // random: mostly pixel traffic; load any store byte before its first read
    while (request_q.size() < REQUEST_TARGET) begin
      pick = $urandom_range(0, 99);
      data = 8'($urandom_range(0, 255));
      a    = 15'($urandom_range(0, STORE_DEPTH - 1));
      if (pick < 38) cmd = CMD_PIX_RD;
      else if (pick < 62) cmd = CMD_PIX_WR;
      else if (pick < 70) cmd = CMD_BYTE_WR;
      else if (pick < 76) cmd = CMD_SET_X;
      else if (pick < 82) cmd = CMD_SET_Y;
      else if (pick < 86) cmd = CMD_X_HOLD;
      else if (pick < 90) cmd = CMD_Y_HOLD;
      else if (pick < 94) cmd = CMD_X_DIR;
      else if (pick < 97) cmd = CMD_Y_DIR;
      else cmd = 4'($urandom_range(CMD_RESERVED_FIRST, CMD_RESERVED_LAST));

      case (cmd)
        CMD_SET_Y: begin
          // bias toward the protected rows now and then
          if ($urandom_range(0, 3) == 0) data = 8'($urandom_range(0, 8'h17));
        end
        CMD_X_HOLD, CMD_Y_HOLD, CMD_X_DIR, CMD_Y_DIR: data = flag_byte();
        CMD_BYTE_WR: begin
          // preload around the cursor half the time
          if ($urandom_range(0, 1) == 0) a = cursor_addr() + 15'($urandom_range(0, 3));
        end
        CMD_PIX_RD, CMD_PIX_WR: begin
          if (!frame_written[cursor_addr()] &&
              (cmd == CMD_PIX_RD || cursor_addr() > PROTECT_LIMIT))
            queue_request(CMD_BYTE_WR, cursor_addr(), 8'($urandom_range(0, 255)));
        end
        default: ;
      endcase
      queue_request(cmd, a, data);
    end
    total_requests = request_q.size();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (requests_sent < total_requests || read_data_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests: %0d pixel reads, %0d pixel writes (%0d protected),",
             total_requests, n_pix_rd, n_pix_wr, n_protected);
    $display("  %0d byte writes; checked %0d responses, input held off for %0d cycles.",
             n_byte_wr, results_checked, stalled_cycles);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // bound the run well past the slowest legal pacing
  initial begin : watchdog
    #8000000;
    $display("Timed out with %0d of %0d requests sent, %0d responses pending.",
             requests_sent, total_requests, read_data_q.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
